[sv/wis_pkg.sv]
`default_nettype none

package wis_pkg;

  localparam int unsigned SHIFT_CAP_DEF = 24;

  localparam int unsigned NOW_W    = 36;
  localparam int unsigned LOCAL_W  = 37;
  localparam int unsigned OFS_W    = 17;
  localparam int unsigned US_W     = 40;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned SOD_W    = 17;
  localparam int unsigned SHAMT_W  = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 40;
  localparam int unsigned PC_W     = 4;

  // one day is 675 << 7 seconds, one hour is 225 << 4 seconds
  localparam int unsigned DAY_LO_W      = 7;
  localparam int unsigned DAY_HI_W      = LOCAL_W - DAY_LO_W;
  localparam int unsigned QUO_W         = 21;
  localparam int unsigned MOD_PROD_W    = 61;
  localparam int unsigned MOD_RECIP_SH  = 40;
  localparam int unsigned HOUR_LO_W     = 4;
  localparam int unsigned HOUR_PROD_W   = 26;
  localparam int unsigned HOUR_RECIP_SH = 21;

  localparam logic [NOW_W-1:0]   CLOCK_VALID_AFTER = 36'd1579461559;
  localparam logic [SOD_W:0]     SECS_PER_DAY      = 18'd86400;
  localparam logic [SOD_W-1:0]   SECS_PER_HOUR     = 17'd3600;
  localparam logic [HOUR_W-1:0]  HOURS_PER_DAY     = 5'd24;
  localparam logic [COUNT_W-1:0] COUNT_CAP         = 5'd24;
  localparam logic [19:0]        US_PER_SEC        = 20'd1000000;
  localparam logic [US_W-1:0]    FLAT_SLEEP_US     = 40'd3600000000;
  localparam logic [9:0]         DAY_HI_DIV        = 10'd675;
  localparam logic [30:0]        DAY_HI_RECIP      = 31'd1628906116;
  localparam logic [13:0]        HOUR_HI_RECIP     = 14'd9321;

  localparam logic [CFG_IDX_W-1:0] REG_FETCH_HOUR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_END   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UTC_OFFSET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_BASE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_MAX   = 3'd5;

  localparam logic [HOUR_W-1:0] FETCH_HOUR_RST  = 5'd6;
  localparam logic [HOUR_W-1:0] QUIET_START_RST = 5'd22;
  localparam logic [HOUR_W-1:0] QUIET_END_RST   = 5'd5;
  localparam logic [US_W-1:0]   RETRY_BASE_RST  = 40'd3600000000;
  localparam logic [US_W-1:0]   RETRY_MAX_RST   = 40'd86400000000;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MOD_Q,
    OP_MOD_R,
    OP_HOUR_Q,
    OP_HOUR_R,
    OP_SEARCH_INIT,
    OP_SEARCH,
    OP_SECS,
    OP_SCALE,
    OP_FLAT,
    OP_RETRY
  } op_t;

  typedef enum logic [2:0] {
    BR_NONE,
    BR_ALWAYS,
    BR_RETRY,
    BR_INVALID,
    BR_SEARCH
  } br_t;

  typedef struct packed {
    op_t  op;
    br_t  br;
    pc_t  target;
    logic fin;
  } ctl_t;

  localparam pc_t S_LOAD        = 4'd0;
  localparam pc_t S_CHECK       = 4'd1;
  localparam pc_t S_MOD_Q       = 4'd2;
  localparam pc_t S_MOD_R       = 4'd3;
  localparam pc_t S_HOUR_Q      = 4'd4;
  localparam pc_t S_HOUR_R      = 4'd5;
  localparam pc_t S_SEARCH_INIT = 4'd6;
  localparam pc_t S_SEARCH      = 4'd7;
  localparam pc_t S_SECS        = 4'd8;
  localparam pc_t S_SCALE       = 4'd9;
  localparam pc_t S_FLAT        = 4'd10;
  localparam pc_t S_RETRY       = 4'd11;

  function automatic ctl_t ucode(input pc_t pc);
    ctl_t c;
    c = '{op: OP_NOP, br: BR_NONE, target: S_LOAD, fin: 1'b0};
    unique case (pc)
      S_LOAD:        c = '{op: OP_LOAD,        br: BR_RETRY,   target: S_RETRY,  fin: 1'b0};
      S_CHECK:       c = '{op: OP_NOP,         br: BR_INVALID, target: S_FLAT,   fin: 1'b0};
      S_MOD_Q:       c = '{op: OP_MOD_Q,       br: BR_NONE,    target: S_LOAD,   fin: 1'b0};
      S_MOD_R:       c = '{op: OP_MOD_R,       br: BR_NONE,    target: S_LOAD,   fin: 1'b0};
      S_HOUR_Q:      c = '{op: OP_HOUR_Q,      br: BR_NONE,    target: S_LOAD,   fin: 1'b0};
      S_HOUR_R:      c = '{op: OP_HOUR_R,      br: BR_NONE,    target: S_LOAD,   fin: 1'b0};
      S_SEARCH_INIT: c = '{op: OP_SEARCH_INIT, br: BR_NONE,    target: S_LOAD,   fin: 1'b0};
      S_SEARCH:      c = '{op: OP_SEARCH,      br: BR_SEARCH,  target: S_SEARCH, fin: 1'b0};
      S_SECS:        c = '{op: OP_SECS,        br: BR_NONE,    target: S_LOAD,   fin: 1'b0};
      S_SCALE:       c = '{op: OP_SCALE,       br: BR_ALWAYS,  target: S_LOAD,   fin: 1'b1};
      S_FLAT:        c = '{op: OP_FLAT,        br: BR_ALWAYS,  target: S_LOAD,   fin: 1'b1};
      S_RETRY:       c = '{op: OP_RETRY,       br: BR_ALWAYS,  target: S_LOAD,   fin: 1'b1};
      default:       c = '{op: OP_NOP,         br: BR_ALWAYS,  target: S_LOAD,   fin: 1'b0};
    endcase
    return c;
  endfunction

  function automatic logic may_wake(input logic [HOUR_W-1:0] h,
                                    input logic [HOUR_W-1:0] q_start,
                                    input logic [HOUR_W-1:0] q_end,
                                    input logic [HOUR_W-1:0] fetch);
    logic quiet;
    if (q_start == q_end) begin
      quiet = 1'b0;
    end else if (q_start < q_end) begin
      quiet = (h >= q_start) && (h < q_end);
    end else begin
      quiet = (h >= q_start) || (h < q_end);
    end
    return !quiet || (h == fetch);
  endfunction

endpackage

`default_nettype wire

[sv/wake_interval_scheduler_core.sv]
// A retry runs the load and retry steps; a success with the clock unset runs load, clock check
// and flat steps; a success with a valid clock runs a quotient and a remainder step each for the
// day remainder and the hour split, a search of the following hours, then seconds and scaling to
// us. One request is worked at a time; the next is taken the cycle after the result is loaded.
// Reset (synchronous, rst_n low) clears the failure count and control, and restores fetch hour 6,
// quiet 22 to 5, zero offset, 1 h, 24 h.
`default_nettype none

module wake_interval_scheduler_core #(
  parameter int unsigned SHIFT_CAP = wis_pkg::SHIFT_CAP_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 in_opcode,
  input  wire  [wis_pkg::NOW_W-1:0]           in_now_utc,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [wis_pkg::US_W-1:0]            out_sleep_us,
  output logic                                out_flat_hour_used,
  output logic                                out_retry_pending,
  input  wire                                 cfg_we,
  input  wire  [wis_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [wis_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam logic [wis_pkg::SHAMT_W-1:0] SHIFT_CAP_V = wis_pkg::SHAMT_W'(SHIFT_CAP);

  logic [wis_pkg::HOUR_W-1:0]  fetch_hour_r;
  logic [wis_pkg::HOUR_W-1:0]  quiet_start_r;
  logic [wis_pkg::HOUR_W-1:0]  quiet_end_r;
  logic [wis_pkg::OFS_W-1:0]   utc_offset_r;
  logic [wis_pkg::US_W-1:0]    retry_base_r;
  logic [wis_pkg::US_W-1:0]    retry_max_r;

  logic                        busy_r, busy_nxt;
  wis_pkg::pc_t                pc_r, pc_nxt;
  logic                        opcode_r;
  logic [wis_pkg::NOW_W-1:0]   now_r;
  logic [wis_pkg::COUNT_W-1:0] count_r, count_nxt;

  logic [wis_pkg::LOCAL_W-1:0] local_r, local_nxt;
  logic [wis_pkg::QUO_W-1:0]   quo_r, quo_nxt;
  logic [wis_pkg::SOD_W-1:0]   rem_r, rem_nxt;
  logic [wis_pkg::HOUR_W-1:0]  hour_r, hour_nxt;
  logic [wis_pkg::HOUR_W-1:0]  h_r, h_nxt;
  logic [wis_pkg::HOUR_W-1:0]  k_r, k_nxt;
  logic [wis_pkg::HOUR_W-1:0]  ahead_r, ahead_nxt;
  logic [wis_pkg::SOD_W-1:0]   secs_r, secs_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [wis_pkg::US_W-1:0]    sleep_r, sleep_nxt;
  logic                        flat_r, flat_nxt;
  logic                        pending_r, pending_nxt;

  wis_pkg::ctl_t               ctl;
  logic                        in_acc;
  logic                        adv;
  logic                        clk_valid;
  logic                        wake;
  logic                        take_br;

  logic [wis_pkg::LOCAL_W:0]     local_sum;
  logic [wis_pkg::DAY_HI_W-1:0]  day_hi;
  logic [wis_pkg::MOD_PROD_W-1:0] mod_prod;
  logic [wis_pkg::DAY_HI_W-1:0]  day_rem;
  logic [wis_pkg::HOUR_PROD_W-1:0] hour_prod;
  logic [wis_pkg::SOD_W-1:0]     hour_secs;
  logic [wis_pkg::HOUR_W:0]      h_inc;
  logic [wis_pkg::SOD_W-1:0]     ahead_secs;
  logic [36:0]                   scaled;
  logic [wis_pkg::SHAMT_W-1:0]   count_ext;
  logic [wis_pkg::SHAMT_W-1:0]   shamt;
  logic [wis_pkg::US_W-1:0]      max_shr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fetch_hour_r  <= wis_pkg::FETCH_HOUR_RST;
      quiet_start_r <= wis_pkg::QUIET_START_RST;
      quiet_end_r   <= wis_pkg::QUIET_END_RST;
      utc_offset_r  <= '0;
      retry_base_r  <= wis_pkg::RETRY_BASE_RST;
      retry_max_r   <= wis_pkg::RETRY_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wis_pkg::REG_FETCH_HOUR:  fetch_hour_r  <= cfg_data[wis_pkg::HOUR_W-1:0];
        wis_pkg::REG_QUIET_START: quiet_start_r <= cfg_data[wis_pkg::HOUR_W-1:0];
        wis_pkg::REG_QUIET_END:   quiet_end_r   <= cfg_data[wis_pkg::HOUR_W-1:0];
        wis_pkg::REG_UTC_OFFSET:  utc_offset_r  <= cfg_data[wis_pkg::OFS_W-1:0];
        wis_pkg::REG_RETRY_BASE:  retry_base_r  <= cfg_data[wis_pkg::US_W-1:0];
        wis_pkg::REG_RETRY_MAX:   retry_max_r   <= cfg_data[wis_pkg::US_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall           = busy_r;
  assign in_acc             = in_valid && !busy_r;
  assign out_valid          = out_valid_r;
  assign out_sleep_us       = sleep_r;
  assign out_flat_hour_used = flat_r;
  assign out_retry_pending  = pending_r;

  assign ctl       = wis_pkg::ucode(pc_r);
  // hold the final step while the previous result is still waiting
  assign adv       = busy_r && !(ctl.fin && out_valid_r && out_stall);
  assign clk_valid = now_r > wis_pkg::CLOCK_VALID_AFTER;
  assign wake      = wis_pkg::may_wake(h_r, quiet_start_r, quiet_end_r, fetch_hour_r);

  assign local_sum  = $signed({2'b00, now_r})
                    + {{(wis_pkg::LOCAL_W + 1 - wis_pkg::OFS_W){utc_offset_r[wis_pkg::OFS_W-1]}},
                       utc_offset_r};
  assign day_hi     = local_r[wis_pkg::LOCAL_W-1:wis_pkg::DAY_LO_W];
  assign mod_prod   = wis_pkg::MOD_PROD_W'(day_hi)
                    * wis_pkg::MOD_PROD_W'(wis_pkg::DAY_HI_RECIP);
  assign day_rem    = day_hi - wis_pkg::DAY_HI_W'(quo_r) * wis_pkg::DAY_HI_W'(wis_pkg::DAY_HI_DIV);
  assign hour_prod  = wis_pkg::HOUR_PROD_W'(rem_r[wis_pkg::SOD_W-1:wis_pkg::HOUR_LO_W])
                    * wis_pkg::HOUR_PROD_W'(wis_pkg::HOUR_HI_RECIP);
  assign hour_secs  = wis_pkg::SOD_W'(hour_r) * wis_pkg::SECS_PER_HOUR;
  assign h_inc      = {1'b0, h_r} + 6'd1;
  assign ahead_secs = wis_pkg::SOD_W'(ahead_r) * wis_pkg::SECS_PER_HOUR;
  assign scaled     = 37'(secs_r) * 37'(wis_pkg::US_PER_SEC);
  assign count_ext  = {1'b0, count_r};
  assign shamt      = (count_ext < SHIFT_CAP_V) ? count_ext : SHIFT_CAP_V;
  assign max_shr    = retry_max_r >> shamt;

  always_comb begin
    unique case (ctl.br)
      wis_pkg::BR_NONE:    take_br = 1'b0;
      wis_pkg::BR_ALWAYS:  take_br = 1'b1;
      wis_pkg::BR_RETRY:   take_br = opcode_r;
      wis_pkg::BR_INVALID: take_br = !clk_valid;
      wis_pkg::BR_SEARCH:  take_br = !wake && (k_r != wis_pkg::HOURS_PER_DAY);
      default:             take_br = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    count_nxt     = count_r;
    local_nxt     = local_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    hour_nxt      = hour_r;
    h_nxt         = h_r;
    k_nxt         = k_r;
    ahead_nxt     = ahead_r;
    secs_nxt      = secs_r;
    out_valid_nxt = out_valid_r && out_stall;
    sleep_nxt     = sleep_r;
    flat_nxt      = flat_r;
    pending_nxt   = pending_r;

    if (in_acc) begin
      busy_nxt = 1'b1;
      pc_nxt   = wis_pkg::S_LOAD;
    end

    if (adv) begin
      pc_nxt = take_br ? ctl.target : pc_r + 1'b1;
      if (ctl.fin) begin
        busy_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
      end
      unique case (ctl.op)
        wis_pkg::OP_NOP: begin
        end
        wis_pkg::OP_LOAD: begin
          local_nxt = local_sum[wis_pkg::LOCAL_W-1:0];
        end
        wis_pkg::OP_MOD_Q: begin
          quo_nxt = mod_prod[wis_pkg::MOD_PROD_W-1:wis_pkg::MOD_RECIP_SH];
        end
        wis_pkg::OP_MOD_R: begin
          rem_nxt = {day_rem[wis_pkg::SOD_W-wis_pkg::DAY_LO_W-1:0],
                     local_r[wis_pkg::DAY_LO_W-1:0]};
        end
        wis_pkg::OP_HOUR_Q: begin
          hour_nxt = hour_prod[wis_pkg::HOUR_PROD_W-1:wis_pkg::HOUR_RECIP_SH];
        end
        wis_pkg::OP_HOUR_R: begin
          rem_nxt = rem_r - hour_secs;
        end
        wis_pkg::OP_SEARCH_INIT: begin
          h_nxt     = (hour_r == wis_pkg::HOURS_PER_DAY - 1'b1) ? '0 : hour_r + 1'b1;
          k_nxt     = wis_pkg::HOUR_W'(1);
          ahead_nxt = wis_pkg::HOUR_W'(1);
        end
        wis_pkg::OP_SEARCH: begin
          if (wake) begin
            ahead_nxt = k_r;
          end else begin
            h_nxt = (h_inc >= {1'b0, wis_pkg::HOURS_PER_DAY})
                  ? wis_pkg::HOUR_W'(h_inc - {1'b0, wis_pkg::HOURS_PER_DAY})
                  : h_inc[wis_pkg::HOUR_W-1:0];
            k_nxt = k_r + 1'b1;
          end
        end
        wis_pkg::OP_SECS: begin
          secs_nxt = (ahead_secs > rem_r) ? ahead_secs - rem_r : wis_pkg::SOD_W'(1);
        end
        wis_pkg::OP_SCALE: begin
          sleep_nxt   = wis_pkg::US_W'(scaled);
          flat_nxt    = 1'b0;
          pending_nxt = 1'b0;
          count_nxt   = '0;
        end
        wis_pkg::OP_FLAT: begin
          sleep_nxt   = wis_pkg::FLAT_SLEEP_US;
          flat_nxt    = 1'b1;
          pending_nxt = 1'b0;
          count_nxt   = '0;
        end
        wis_pkg::OP_RETRY: begin
          sleep_nxt   = (retry_base_r > max_shr) ? retry_max_r : retry_base_r << shamt;
          flat_nxt    = 1'b0;
          pending_nxt = 1'b1;
          if (count_r < wis_pkg::COUNT_CAP) begin
            count_nxt = count_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= wis_pkg::S_LOAD;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      opcode_r <= in_opcode;
      now_r    <= in_now_utc;
    end
    local_r   <= local_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    hour_r    <= hour_nxt;
    h_r       <= h_nxt;
    k_r       <= k_nxt;
    ahead_r   <= ahead_nxt;
    secs_r    <= secs_nxt;
    sleep_r   <= sleep_nxt;
    flat_r    <= flat_nxt;
    pending_r <= pending_nxt;
  end

endmodule

`default_nettype wire

[tb/sv/tb_wake_interval_scheduler_core.sv]
module tb_wake_interval_scheduler_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REQ_SLEEP = 1'b0;
  localparam logic REQ_RETRY = 1'b1;
  localparam int unsigned BACKOFF_CAP = 24;
  localparam int unsigned FAIL_SATURATE = 24;
  localparam longint DAY_SECS = 86400;
  localparam longint HOUR_SECS = 3600;
  localparam int unsigned DAY_HOURS = 24;
  localparam logic [wis_pkg::NOW_W-1:0] MIDNIGHT = 36'd1579478400;
  localparam logic [wis_pkg::US_W-1:0] US_FULL = 40'hFF_FFFF_FFFF;
  localparam int RAND_PER_PHASE = 160;
  localparam int LAST_PHASE = 11;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PCT_CHOICE [4] = '{0, 10, 30, 60};

  typedef struct packed {
    logic                      op;
    logic [wis_pkg::NOW_W-1:0] now;
  } wake_req_t;

  typedef struct packed {
    logic [wis_pkg::US_W-1:0] sleep_us;
    logic                     flat_hour;
    logic                     pending;
  } wake_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = 1'b0;
  logic [wis_pkg::NOW_W-1:0] in_now_utc = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [wis_pkg::US_W-1:0] out_sleep_us;
  logic out_flat_hour_used;
  logic out_retry_pending;
  logic cfg_we = 1'b0;
  logic [wis_pkg::CFG_IDX_W-1:0] cfg_index = wis_pkg::REG_FETCH_HOUR;
  logic [wis_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  wake_req_t send_q [$];
  wake_res_t wake_due [$];
  logic in_xfer = 1'b0;
  bit calm = 1'b0;
  int gap_pct = 0;
  int stall_pct = 0;
  int gap_left = 0;
  int stall_left = 0;
  int mismatches = 0;
  int cycles = 0;

  int unsigned fetch_hr = wis_pkg::FETCH_HOUR_RST;
  int unsigned quiet_from = wis_pkg::QUIET_START_RST;
  int unsigned quiet_to = wis_pkg::QUIET_END_RST;
  longint utc_ofs = 0;
  logic [wis_pkg::US_W-1:0] retry_base = wis_pkg::RETRY_BASE_RST;
  logic [wis_pkg::US_W-1:0] retry_cap = wis_pkg::RETRY_MAX_RST;
  int unsigned fail_cnt = 0;

  wake_interval_scheduler_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_now_utc         (in_now_utc),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_sleep_us       (out_sleep_us),
    .out_flat_hour_used (out_flat_hour_used),
    .out_retry_pending  (out_retry_pending),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit hour_open(int unsigned h);
    bit quiet;
    if (quiet_from == quiet_to) begin
      quiet = 1'b0;
    end else if (quiet_from < quiet_to) begin
      quiet = (h >= quiet_from) && (h < quiet_to);
    end else begin
      quiet = (h >= quiet_from) || (h < quiet_to);
    end
    return !quiet || (h == fetch_hr);
  endfunction

  function automatic wake_res_t predict_wake(logic op, logic [wis_pkg::NOW_W-1:0] now);
    wake_res_t r;
    longint loc_s, sod, into_s, ahead, secs;
    int unsigned cur, shamt;
    bit found;
    r = '0;
    if (op == REQ_SLEEP) begin
      fail_cnt = 0;
      if (now > wis_pkg::CLOCK_VALID_AFTER) begin
        loc_s = longint'(now) + utc_ofs;
        sod = ((loc_s % DAY_SECS) + DAY_SECS) % DAY_SECS;
        cur = int'(sod / HOUR_SECS);
        into_s = sod % HOUR_SECS;
        ahead = 1;
        found = 1'b0;
        for (int unsigned k = 1; k <= DAY_HOURS; k++) begin
          if (!found && hour_open((cur + k) % DAY_HOURS)) begin
            ahead = k;
            found = 1'b1;
          end
        end
        secs = ahead * HOUR_SECS - into_s;
        if (secs < 1) secs = 1;
        r.sleep_us = wis_pkg::US_W'(secs * 1000000);
      end else begin
        r.sleep_us = wis_pkg::FLAT_SLEEP_US;
        r.flat_hour = 1'b1;
      end
    end else begin
      shamt = (fail_cnt < BACKOFF_CAP) ? fail_cnt : BACKOFF_CAP;
      if (retry_base > (retry_cap >> shamt)) begin
        r.sleep_us = retry_cap;
      end else begin
        r.sleep_us = retry_base << shamt;
      end
      if (fail_cnt < FAIL_SATURATE) fail_cnt++;
    end
    r.pending = (fail_cnt != 0);
    return r;
  endfunction

  function automatic logic [wis_pkg::NOW_W-1:0] pick_now();
    logic [63:0] raw;
    longint t, lag;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return raw[wis_pkg::NOW_W-1:0] >> $urandom_range(6, 35);
      1: return wis_pkg::CLOCK_VALID_AFTER - 2 + $urandom_range(0, 4);
      2, 3: begin
        t = longint'(wis_pkg::CLOCK_VALID_AFTER) + 100000 + longint'(raw[33:0]);
        lag = (((t + utc_ofs) % HOUR_SECS) + HOUR_SECS) % HOUR_SECS;
        case ($urandom_range(0, 3))
          0: t = t - lag;
          1: t = t - lag + 1;
          2: t = t - lag + HOUR_SECS - 1;
          default: t = t - lag - 1;
        endcase
        return t[wis_pkg::NOW_W-1:0];
      end
      default: return raw[wis_pkg::NOW_W-1:0];
    endcase
  endfunction

  function automatic int unsigned pick_hour();
    return ($urandom_range(0, 5) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
  endfunction

  function automatic logic [wis_pkg::US_W-1:0] pick_us();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[wis_pkg::US_W-1:0] >> $urandom_range(0, 39);
  endfunction

  task automatic put_reg(logic [wis_pkg::CFG_IDX_W-1:0] idx,
                         logic [wis_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic apply_settings(int unsigned fh, int unsigned qs, int unsigned qe, int ofs,
                                logic [wis_pkg::US_W-1:0] base,
                                logic [wis_pkg::US_W-1:0] cap);
    logic [wis_pkg::CFG_DATA_W-1:0] ofs_word;
    ofs_word = '0;
    ofs_word[wis_pkg::OFS_W-1:0] = ofs[wis_pkg::OFS_W-1:0];
    put_reg(wis_pkg::REG_FETCH_HOUR, wis_pkg::CFG_DATA_W'(fh));
    put_reg(wis_pkg::REG_QUIET_START, wis_pkg::CFG_DATA_W'(qs));
    put_reg(wis_pkg::REG_QUIET_END, wis_pkg::CFG_DATA_W'(qe));
    put_reg(wis_pkg::REG_UTC_OFFSET, ofs_word);
    put_reg(wis_pkg::REG_RETRY_BASE, base);
    put_reg(wis_pkg::REG_RETRY_MAX, cap);
    @(negedge clk);
    cfg_we <= 1'b0;
    fetch_hr = fh;
    quiet_from = qs;
    quiet_to = qe;
    utc_ofs = ofs;
    retry_base = base;
    retry_cap = cap;
    @(posedge clk);
    #1;
  endtask

  task automatic queue_random(int n);
    int left, run;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 7) begin
        run = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 4);
        repeat (run) send_q.push_back('{REQ_RETRY, pick_now()});
        send_q.push_back('{REQ_SLEEP, pick_now()});
        left -= run + 1;
      end else begin
        send_q.push_back('{1'($urandom), pick_now()});
        left--;
      end
    end
  endtask

  task automatic drain();
    while (send_q.size() != 0 || in_valid || wake_due.size() != 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  // input driver
  always @(negedge clk) begin
    wake_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_xfer) begin
      if (calm) gap_left = 0;
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < gap_pct) begin
        gap_left = $urandom_range(0, 18);
        in_valid <= 1'b0;
      end else if (send_q.size() != 0) begin
        req = send_q.pop_front();
        in_valid <= 1'b1;
        in_opcode <= req.op;
        in_now_utc <= req.now;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if (!rst_n || calm) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // check results, then predict from the accepted request
  always @(posedge clk) begin
    wake_res_t due;
    if (!rst_n) begin
      in_xfer <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (wake_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result sleep_us %0d flat %0b pending %0b", $time,
                   out_sleep_us, out_flat_hour_used, out_retry_pending);
        end else begin
          due = wake_due.pop_front();
          if (out_sleep_us !== due.sleep_us || out_flat_hour_used !== due.flat_hour ||
              out_retry_pending !== due.pending) begin
            mismatches++;
            $display("%0t: expected sleep_us %0d flat %0b pending %0b, got %0d %0b %0b",
                     $time, due.sleep_us, due.flat_hour, due.pending,
                     out_sleep_us, out_flat_hour_used, out_retry_pending);
          end
        end
      end
      in_xfer <= in_valid && !in_stall;
      if (in_valid && !in_stall) wake_due.push_back(predict_wake(in_opcode, in_now_utc));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    #1;
    gap_pct = 20;
    stall_pct = 20;
    send_q.push_back('{REQ_SLEEP, '0});
    send_q.push_back('{REQ_SLEEP, wis_pkg::CLOCK_VALID_AFTER});
    send_q.push_back('{REQ_SLEEP, wis_pkg::CLOCK_VALID_AFTER + 1});
    send_q.push_back('{REQ_SLEEP, '1});
    send_q.push_back('{REQ_SLEEP, MIDNIGHT + 20 * 3600});
    send_q.push_back('{REQ_SLEEP, MIDNIGHT + 21 * 3600 + 3599});
    send_q.push_back('{REQ_SLEEP, MIDNIGHT + 86400 + 3 * 3600 + 1800});
    send_q.push_back('{REQ_SLEEP, MIDNIGHT + 86400 + 4 * 3600 + 3599});
    send_q.push_back('{REQ_SLEEP, MIDNIGHT + 86400 + 5 * 3600});
    send_q.push_back('{REQ_SLEEP, MIDNIGHT + 86400 + 23 * 3600 + 3599});
    for (int i = 0; i < 8; i++) send_q.push_back('{REQ_RETRY, (i % 2 == 0) ? '0 : '1});
    send_q.push_back('{REQ_SLEEP, MIDNIGHT});
    send_q.push_back('{REQ_RETRY, MIDNIGHT});
    drain();

    for (int ph = 1; ph <= LAST_PHASE; ph++) begin
      repeat (4) @(posedge clk);
      case (ph)
        1: apply_settings(0, 0, 0, -65536, 1, US_FULL);
        2: apply_settings(31, 0, 24, 65535, '0, '0);
        3: apply_settings(23, 23, 0, 50400, US_FULL, US_FULL);
        4: apply_settings(24, 30, 3, -50400, 1, 1);
        LAST_PHASE: apply_settings(wis_pkg::FETCH_HOUR_RST, wis_pkg::QUIET_START_RST,
                                   wis_pkg::QUIET_END_RST, 0,
                                   wis_pkg::RETRY_BASE_RST, wis_pkg::RETRY_MAX_RST);
        default: apply_settings(pick_hour(), pick_hour(), pick_hour(),
                                ($urandom_range(0, 3) == 0) ?
                                  int'($urandom_range(0, 131071)) - 65536 :
                                  int'($urandom_range(0, 100800)) - 50400,
                                pick_us(), pick_us());
      endcase
      if (ph == LAST_PHASE) begin
        calm = 1'b1;
      end else begin
        gap_pct = PCT_CHOICE[$urandom_range(0, 3)];
        stall_pct = PCT_CHOICE[$urandom_range(0, 3)];
      end
      queue_random(RAND_PER_PHASE);
      drain();
    end

    repeat (80) @(posedge clk);
    if (mismatches == 0 && wake_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
sv/wis_pkg.sv
sv/wake_interval_scheduler_core.sv
tb/sv/tb_wake_interval_scheduler_core.sv
